@@ hdl/htcb_pkg.sv @@
// shared constants, field widths, codes and the result type of the chained hash table
// no dependencies
package htcb_pkg;

  localparam int unsigned DefBuckets = 16;
  localparam int unsigned DefSlots   = 8;

  localparam int unsigned KeyW    = 31;
  localparam int unsigned CfgW    = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned BucketW = 4;
  localparam int unsigned PosW    = 3;
  localparam int unsigned CountW  = 4;

  localparam logic [CfgW-1:0] SizeReset = 5'd10;

  typedef enum logic [0:0] {
    OpInsert = 1'b0,
    OpDelete = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StatInserted = 2'd0,
    StatDeleted  = 2'd1,
    StatNotFound = 2'd2,
    StatFull     = 2'd3
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [BucketW-1:0]  bucket;
    logic [PosW-1:0]     position;
    logic [CountW-1:0]   bucket_count;
  } htcb_res_t;

endpackage

@@ hdl/htcb_in_if.sv @@
// request channel of the chained hash table: opcode and key with valid/ready
// depends on htcb_pkg
interface htcb_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [htcb_pkg::KeyW-1:0]  key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink (input valid, input opcode, input key, output ready);
endinterface

@@ hdl/htcb_out_if.sv @@
// result channel of the chained hash table: status, bucket, position and count
// depends on htcb_pkg
interface htcb_out_if;
  logic                          valid;
  logic                          ready;
  logic [htcb_pkg::StatusW-1:0]  status;
  logic [htcb_pkg::BucketW-1:0]  bucket;
  logic [htcb_pkg::PosW-1:0]     position;
  logic [htcb_pkg::CountW-1:0]   bucket_count;

  modport source (output valid, output status, output bucket, output position,
                  output bucket_count, input ready);
  modport sink (input valid, input status, input bucket, input position,
                input bucket_count, output ready);
endinterface

@@ hdl/htcb_mod.sv @@
// multi-cycle remainder unit: key modulo the clamped table size, eight key bits a cycle
// depends on htcb_pkg
module htcb_mod #(
  parameter int unsigned Buckets = htcb_pkg::DefBuckets
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [htcb_pkg::KeyW-1:0]  key_i,
  input  logic [htcb_pkg::CfgW-1:0]  size_i,
  output logic                       done_o,
  output logic [htcb_pkg::CfgW-1:0]  rem_o
);
  import htcb_pkg::*;

  localparam int unsigned StepBits = 8;
  localparam int unsigned Iters    = (KeyW + StepBits - 1) / StepBits;
  localparam int unsigned IterW    = (Iters > 1) ? $clog2(Iters) : 1;
  localparam int unsigned PadW     = Iters * StepBits;

  logic              busy_q;
  logic              done_q;
  logic [IterW-1:0]  iter_q;
  logic [PadW-1:0]   sh_q;
  logic [CfgW-1:0]   rem_q;
  logic [CfgW-1:0]   div_q;
  logic [CfgW-1:0]   div_eff;
  logic [CfgW-1:0]   rem_step;

  // zero acts as one, sizes above the table clamp to the table
  always_comb begin
    if (size_i == '0) begin
      div_eff = CfgW'(1);
    end else if (32'(size_i) > 32'(Buckets)) begin
      div_eff = CfgW'(Buckets);
    end else begin
      div_eff = size_i;
    end
  end

  // restoring remainder over one key byte
  always_comb begin
    logic [CfgW:0] r;
    r = {1'b0, rem_q};
    for (int i = 0; i < StepBits; i++) begin
      r = {r[CfgW-1:0], sh_q[PadW-1-i]};
      if (r >= {1'b0, div_q}) begin
        r = r - {1'b0, div_q};
      end
    end
    rem_step = r[CfgW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
      sh_q   <= '0;
      rem_q  <= '0;
      div_q  <= CfgW'(1);
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      iter_q <= '0;
      sh_q   <= PadW'(key_i);
      rem_q  <= '0;
      div_q  <= div_eff;
    end else if (busy_q) begin
      rem_q  <= rem_step;
      sh_q   <= sh_q << StepBits;
      iter_q <= iter_q + IterW'(1);
      if (iter_q == IterW'(Iters - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ hdl/htcb_engine.sv @@
// bucket engine: count and entry memories, count clearing pass, insert, search and shift
// depends on htcb_pkg, htcb_in_if and htcb_mod
module htcb_engine #(
  parameter int unsigned Buckets = htcb_pkg::DefBuckets,
  parameter int unsigned Slots   = htcb_pkg::DefSlots
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  htcb_in_if.sink                    item_i,
  input  logic [htcb_pkg::CfgW-1:0]  size_i,
  output logic                       res_valid_o,
  output htcb_pkg::htcb_res_t        res_o,
  input  logic                       res_ready_i
);
  import htcb_pkg::*;

  localparam int unsigned BW         = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned SW         = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CW         = $clog2(Slots + 1);
  localparam int unsigned AW         = BW + SW;
  localparam int unsigned EntryDepth = 2 ** AW;

  typedef enum logic [2:0] {
    Clearing, Idle, Hashing, Lookup, Decide, Scan, Shift, Done
  } state_e;

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [BW-1:0]    bucket_q, bucket_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [SW-1:0]    idx_q, idx_d;
  logic [BW-1:0]    clr_q, clr_d;
  htcb_res_t        res_q, res_d;

  logic [KeyW-1:0]  ent_mem [EntryDepth];
  logic [CW-1:0]    cnt_mem [Buckets];
  logic [KeyW-1:0]  ent_rdata_q;
  logic [CW-1:0]    cnt_rdata_q;

  logic             ent_we;
  logic [AW-1:0]    ent_waddr;
  logic [KeyW-1:0]  ent_wdata;
  logic [SW-1:0]    rd_idx;
  logic             cnt_we;
  logic [BW-1:0]    cnt_waddr;
  logic [CW-1:0]    cnt_wdata;
  logic             more;

  logic             mod_start;
  logic             mod_done;
  logic [CfgW-1:0]  mod_rem;

  htcb_mod #(
    .Buckets (Buckets)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (item_i.key),
    .size_i  (size_i),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign item_i.ready = (state_q == Idle);
  assign more         = (CW'(idx_q) + CW'(1)) < cnt_q;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    bucket_d  = bucket_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    clr_d     = clr_q;
    res_d     = res_q;
    ent_we    = 1'b0;
    ent_waddr = {bucket_q, idx_q};
    ent_wdata = key_q;
    rd_idx    = idx_q;
    cnt_we    = 1'b0;
    cnt_waddr = bucket_q;
    cnt_wdata = cnt_q;
    mod_start = 1'b0;
    case (state_q)
      Clearing: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
        clr_d     = clr_q + BW'(1);
        if (clr_q == BW'(Buckets - 1)) begin
          state_d = Idle;
        end
      end
      Idle: begin
        if (item_i.valid) begin
          op_d      = op_e'(item_i.opcode);
          key_d     = item_i.key;
          mod_start = 1'b1;
          state_d   = Hashing;
        end
      end
      Hashing: begin
        if (mod_done) begin
          bucket_d = BW'(mod_rem);
          state_d  = Lookup;
        end
      end
      Lookup: begin
        state_d = Decide;
      end
      Decide: begin
        cnt_d         = cnt_rdata_q;
        res_d.bucket  = BucketW'(bucket_q);
        res_d.position = '0;
        if (op_q == OpInsert) begin
          if (cnt_rdata_q >= CW'(Slots)) begin
            res_d.status       = StatFull;
            res_d.bucket_count = CountW'(cnt_rdata_q);
          end else begin
            ent_we             = 1'b1;
            ent_waddr          = {bucket_q, SW'(cnt_rdata_q)};
            cnt_we             = 1'b1;
            cnt_wdata          = cnt_rdata_q + CW'(1);
            res_d.status       = StatInserted;
            res_d.position     = PosW'(cnt_rdata_q);
            res_d.bucket_count = CountW'(cnt_rdata_q + CW'(1));
          end
          state_d = Done;
        end else if (cnt_rdata_q == '0) begin
          res_d.status       = StatNotFound;
          res_d.bucket_count = '0;
          state_d            = Done;
        end else begin
          rd_idx  = '0;
          idx_d   = '0;
          state_d = Scan;
        end
      end
      Scan: begin
        if (ent_rdata_q == key_q) begin
          res_d.position = PosW'(idx_q);
          if (more) begin
            rd_idx  = idx_q + SW'(1);
            idx_d   = idx_q + SW'(1);
            state_d = Shift;
          end else begin
            cnt_we             = 1'b1;
            cnt_wdata          = cnt_q - CW'(1);
            res_d.status       = StatDeleted;
            res_d.bucket_count = CountW'(cnt_q - CW'(1));
            state_d            = Done;
          end
        end else if (more) begin
          rd_idx = idx_q + SW'(1);
          idx_d  = idx_q + SW'(1);
        end else begin
          res_d.status       = StatNotFound;
          res_d.bucket_count = CountW'(cnt_q);
          state_d            = Done;
        end
      end
      Shift: begin
        // move the entry just read one slot down
        ent_we    = 1'b1;
        ent_waddr = {bucket_q, idx_q - SW'(1)};
        ent_wdata = ent_rdata_q;
        if (more) begin
          rd_idx = idx_q + SW'(1);
          idx_d  = idx_q + SW'(1);
        end else begin
          cnt_we             = 1'b1;
          cnt_wdata          = cnt_q - CW'(1);
          res_d.status       = StatDeleted;
          res_d.bucket_count = CountW'(cnt_q - CW'(1));
          state_d            = Done;
        end
      end
      Done: begin
        if (res_ready_i) begin
          state_d = Idle;
        end
      end
      default: begin
        state_d = Idle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= Clearing;
      op_q     <= OpInsert;
      key_q    <= '0;
      bucket_q <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      clr_q    <= '0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      key_q    <= key_d;
      bucket_q <= bucket_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      clr_q    <= clr_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata_q <= ent_mem[{bucket_q, rd_idx}];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata_q <= cnt_mem[bucket_q];
  end

  assign res_valid_o = (state_q == Done);
  assign res_o       = res_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> (cnt_wdata <= CW'(Slots)))
    else $error("bucket count written above slot limit");

  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Scan || state_q == Shift) |-> (CW'(idx_q) < cnt_q))
    else $error("search index beyond bucket count");

  a_shift_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Shift) |-> (idx_q != '0))
    else $error("shift with no lower slot");

  a_mod_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == Hashing))
    else $error("remainder finished outside hashing");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Done && res_q.status == StatFull) |-> (cnt_q == CW'(Slots)))
    else $error("bucket full reported on a bucket with room");

endmodule

@@ hdl/hash_table_chained_buckets.sv @@
// Separate-chaining hash table, bucket = key mod table_size, clamped to 1..Buckets.
// item_i (valid/ready) takes an opcode (insert or delete) and a 31-bit key; result_o
// (valid/ready) returns one item per request: status, bucket, position, bucket_count.
// cfg_we_i/cfg_wdata_i write table_size (reset 10); the user writes it only while the
// block is idle, and the block itself does not enforce this. After reset a clearing pass
// zeroes the bucket counts, with item_i.ready low. One request is worked at a time. The
// remainder unit works first (8 key bits a cycle), then the count memory read and the
// decision, and then the result register loads. An insert, a full bucket or an
// empty-bucket delete goes from the decision straight to the result. A delete walks the
// bucket in the entry memory one slot a cycle, search then shift. item_i.ready returns as
// the result register loads.
// The result stage is a register: the next request is accepted while a result waits;
// a stalled receiver only holds the engine once its next result is ready and the register
// is still occupied.
// depends on htcb_pkg, htcb_in_if, htcb_out_if and htcb_engine
module hash_table_chained_buckets #(
  parameter int unsigned Buckets = htcb_pkg::DefBuckets,
  parameter int unsigned Slots   = htcb_pkg::DefSlots
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [htcb_pkg::CfgW-1:0]  cfg_wdata_i,
  htcb_in_if.sink                    item_i,
  htcb_out_if.source                 result_o
);
  import htcb_pkg::*;

  logic [CfgW-1:0]  size_q;
  logic             res_valid;
  logic             res_ready;
  htcb_res_t        res;
  logic             out_valid_q;
  htcb_res_t        out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  htcb_engine #(
    .Buckets (Buckets),
    .Slots   (Slots)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .size_i      (size_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign res_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.status       = out_q.status;
  assign result_o.bucket       = out_q.bucket;
  assign result_o.position     = out_q.position;
  assign result_o.bucket_count = out_q.bucket_count;

endmodule

@@ bench/tb_hash_table_chained_buckets.sv @@
// self-checking testbench of the chained hash table: directed table, then random phases over
// several table sizes; results are checked field by field against a table model or fixed values
// depends on htcb_pkg, htcb_in_if, htcb_out_if and hash_table_chained_buckets
module tb_hash_table_chained_buckets;
  import htcb_pkg::*;

  localparam int unsigned CycleLimit = 600_000;
  localparam int unsigned Phases     = 12;
  localparam int unsigned PhaseItems = 125;

  typedef enum logic { StepItem, StepSize } step_kind_e;

  typedef struct {
    step_kind_e        kind;
    logic [CfgW-1:0]   size;
    op_e               op;
    logic [KeyW-1:0]   key;
    bit                typed;
    htcb_res_t         res;
  } step_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CfgW-1:0]  cfg_wdata_i;

  htcb_in_if  item_ch ();
  htcb_out_if res_ch ();

  hash_table_chained_buckets dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_ch),
    .result_o    (res_ch)
  );

  logic [KeyW-1:0]  slot_keys [DefBuckets][DefSlots];
  int unsigned      bucket_fill [DefBuckets];
  logic [CfgW-1:0]  size_reg;
  htcb_res_t        due_results [$];
  int unsigned      mismatches;
  bit               idle_on;
  step_t            steps [26];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("hash_table_chained_buckets regression: fail");
    $finish;
  end

  function automatic htcb_res_t apply_to_table(op_e op, logic [KeyW-1:0] key_v);
    int unsigned mod, b, cnt, j, k;
    bit hit;
    htcb_res_t r;
    mod = 32'(size_reg);
    if (mod == 0) mod = 1;
    if (mod > DefBuckets) mod = DefBuckets;
    b = key_v % mod;
    cnt = bucket_fill[b];
    r.status = StatNotFound;
    r.bucket = BucketW'(b);
    r.position = '0;
    if (op == OpInsert) begin
      if (cnt >= DefSlots) begin
        r.status = StatFull;
      end else begin
        slot_keys[b][cnt] = key_v;
        r.position = PosW'(cnt);
        cnt++;
        r.status = StatInserted;
      end
    end else begin
      hit = 1'b0;
      j = 0;
      while (j < cnt && !hit) begin
        if (slot_keys[b][j] == key_v) hit = 1'b1;
        else j++;
      end
      if (hit) begin
        r.position = PosW'(j);
        for (k = j; k + 1 < cnt; k++) slot_keys[b][k] = slot_keys[b][k + 1];
        cnt--;
        r.status = StatDeleted;
      end
    end
    bucket_fill[b] = cnt;
    r.bucket_count = CountW'(cnt);
    return r;
  endfunction

  function automatic bit pick_stored_key(output logic [KeyW-1:0] k);
    int unsigned b, tries;
    k = '0;
    for (tries = 0; tries < 24; tries++) begin
      b = $urandom_range(0, DefBuckets - 1);
      if (bucket_fill[b] != 0) begin
        k = slot_keys[b][$urandom_range(0, bucket_fill[b] - 1)];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function automatic void queue_result(htcb_res_t r);
    due_results = {due_results, r};
  endfunction

  task automatic pause_for_results();
    if (due_results.size() != 0) begin
      item_ch.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clk_i);
    end
  endtask

  task automatic write_size(logic [CfgW-1:0] v);
    pause_for_results();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = v;
  endtask

  task automatic send_item(op_e op, logic [KeyW-1:0] key_v, bit typed, htcb_res_t typed_res);
    htcb_res_t want;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    item_ch.valid  <= 1'b1;
    item_ch.opcode <= op;
    item_ch.key    <= key_v;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    want = apply_to_table(op, key_v);
    if (typed) want = typed_res;
    queue_result(want);
  endtask

  task automatic make_random_item(int unsigned ins_pct, output op_e op,
                                  output logic [KeyW-1:0] key_v);
    int unsigned r;
    op = ($urandom_range(0, 99) < ins_pct) ? OpInsert : OpDelete;
    r = $urandom_range(0, 99);
    // deletes mostly target keys that are really stored
    if (op == OpDelete && r < 65) begin
      if (pick_stored_key(key_v)) return;
    end
    if (r < 75) key_v = KeyW'($urandom_range(0, 255));
    else if (r < 82) key_v = $urandom_range(0, 1) ? '1 : '0;
    else key_v = KeyW'($urandom);
  endtask

  // result side: random stalls, check each item against the oldest expectation
  initial begin
    int unsigned stall_left;
    htcb_res_t want;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d", $time,
                   res_ch.status, res_ch.bucket, res_ch.position, res_ch.bucket_count);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, res_ch.status);
          check_field("bucket", want.bucket, res_ch.bucket);
          check_field("position", want.position, res_ch.position);
          check_field("bucket_count", want.bucket_count, res_ch.bucket_count);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned ph, n, ins_pct;
    op_e op;
    logic [KeyW-1:0] key_v;
    logic [CfgW-1:0] phase_sizes [Phases];

    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    item_ch.valid  <= 1'b0;
    item_ch.opcode <= OpInsert;
    item_ch.key    <= '0;
    size_reg = SizeReset;
    foreach (bucket_fill[b]) bucket_fill[b] = 0;
    mismatches = 0;
    idle_on = 1'b1;

    steps = '{
      '{StepItem, 5'd0,  OpDelete, 31'd0,          1'b1, '{StatNotFound, 4'd0, 3'd0, 4'd0}},
      '{StepItem, 5'd0,  OpInsert, 31'd0,          1'b1, '{StatInserted, 4'd0, 3'd0, 4'd1}},
      '{StepItem, 5'd0,  OpInsert, 31'h7FFF_FFFF,  1'b1, '{StatInserted, 4'd7, 3'd0, 4'd1}},
      '{StepItem, 5'd0,  OpDelete, 31'h7FFF_FFFF,  1'b1, '{StatDeleted, 4'd7, 3'd0, 4'd0}},
      '{StepItem, 5'd0,  OpInsert, 31'd10,         1'b0, '0},
      '{StepItem, 5'd0,  OpInsert, 31'd20,         1'b0, '0},
      '{StepItem, 5'd0,  OpInsert, 31'd30,         1'b0, '0},
      '{StepItem, 5'd0,  OpInsert, 31'd40,         1'b0, '0},
      '{StepItem, 5'd0,  OpInsert, 31'd50,         1'b0, '0},
      '{StepItem, 5'd0,  OpInsert, 31'd60,         1'b0, '0},
      '{StepItem, 5'd0,  OpInsert, 31'd70,         1'b0, '0},
      '{StepItem, 5'd0,  OpInsert, 31'd80,         1'b1, '{StatFull, 4'd0, 3'd0, 4'd8}},
      '{StepItem, 5'd0,  OpDelete, 31'd30,         1'b0, '0},
      '{StepItem, 5'd0,  OpDelete, 31'd30,         1'b0, '0},
      '{StepItem, 5'd0,  OpInsert, 31'd0,          1'b0, '0},
      '{StepItem, 5'd0,  OpDelete, 31'd0,          1'b0, '0},
      '{StepItem, 5'd0,  OpDelete, 31'd0,          1'b0, '0},
      '{StepSize, 5'd0,  OpInsert, 31'd0,          1'b0, '0},
      '{StepItem, 5'd0,  OpInsert, 31'd12345,      1'b0, '0},
      '{StepItem, 5'd0,  OpDelete, 31'd20,         1'b0, '0},
      '{StepSize, 5'd31, OpInsert, 31'd0,          1'b0, '0},
      '{StepItem, 5'd0,  OpInsert, 31'h7FFF_FFFF,  1'b1, '{StatInserted, 4'd15, 3'd0, 4'd1}},
      '{StepItem, 5'd0,  OpDelete, 31'd40,         1'b0, '0},
      '{StepSize, 5'd16, OpInsert, 31'd0,          1'b0, '0},
      '{StepItem, 5'd0,  OpDelete, 31'h7FFF_FFFF,  1'b1, '{StatDeleted, 4'd15, 3'd0, 4'd0}},
      '{StepItem, 5'd0,  OpInsert, 31'd0,          1'b0, '0}
    };

    phase_sizes = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd0, 5'd17, 5'd7, 5'd0, 5'd15, 5'd2,
                    5'd16};
    phase_sizes[5] = CfgW'($urandom_range(0, 31));
    phase_sizes[8] = CfgW'($urandom_range(0, 31));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (steps[i]) begin
      if (steps[i].kind == StepSize) begin
        write_size(steps[i].size);
      end else begin
        send_item(steps[i].op, steps[i].key, steps[i].typed, steps[i].res);
      end
    end

    for (ph = 0; ph < Phases; ph++) begin
      write_size(phase_sizes[ph]);
      idle_on = (ph == Phases - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      ins_pct = $urandom_range(35, 70);
      for (n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 199) == 0) pause_for_results();
        make_random_item(ins_pct, op, key_v);
        send_item(op, key_v, 1'b0, '0);
      end
    end

    pause_for_results();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("hash_table_chained_buckets regression: pass");
    end else begin
      $display("hash_table_chained_buckets regression: fail");
    end
    $finish;
  end

endmodule
